[sv/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
// Each macro is clocked on clk and disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge outside reset.
`define KST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked at the next clock edge.
`define KST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/kst_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the keyed slot toggle allocator.
// No dependencies; imported by every module of the block.
package kst_pkg;

  localparam int NUM_SLOTS_DEF = 32;
  localparam int KEY_BITS_DEF  = 56;

  localparam int KEY_W    = 56;
  localparam int STAMP_W  = 17;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 6;

  typedef enum logic [STATUS_W-1:0] {
    ST_ALLOC   = 2'd0,
    ST_RELEASE = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Per-step control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp;    // capture hit and free flags
    logic apply;  // update the granted cell
    logic alloc;  // 1: allocate, 0: release
  } cell_ctl_t;

endpackage

[sv/kst_cell.sv]
`timescale 1ns / 1ps
// One slot of the allocator: occupancy bit, key and stamp, plus hit/free flags.
// Depends on kst_pkg.
module kst_cell
  import kst_pkg::*;
#(
  parameter int KEY_BITS = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cell_ctl_t           ctl,
  input  logic                grant,
  input  logic [KEY_BITS-1:0] req_key,
  input  logic [STAMP_W-1:0]  req_stamp,
  output logic                hit,
  output logic                free,
  output logic [STAMP_W-1:0]  stamp
);

  logic                occ_r, occ_nxt;
  logic [KEY_BITS-1:0] key_r;
  logic [STAMP_W-1:0]  stamp_r;
  logic                hit_r, free_r;

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.apply && grant) begin
      occ_nxt = ctl.alloc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      hit_r  <= occ_r && (key_r == req_key);
      free_r <= !occ_r;
    end
    if (ctl.apply && grant && ctl.alloc) begin
      key_r   <= req_key;
      stamp_r <= req_stamp;
    end
  end

  assign hit   = hit_r;
  assign free  = free_r;
  assign stamp = stamp_r;

`include "assert_macros.svh"

  `KST_ASSERT(a_occ_only_on_grant, $stable(occ_r) || $past(ctl.apply && grant), "bad occupancy")
  `KST_ASSERT_NEXT(a_alloc_sets_occ, ctl.apply && grant && ctl.alloc, occ_r, "slot not taken")

endmodule

[sv/kst_pick.sv]
`timescale 1ns / 1ps
// Lowest-slot picker: grants the lowest hit, else the lowest free slot.
// Depends on kst_pkg.
module kst_pick
  import kst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic [NUM_SLOTS-1:0] hit_vec,
  input  logic [NUM_SLOTS-1:0] free_vec,
  output logic [NUM_SLOTS-1:0] grant,
  output logic                 is_hit,
  output logic                 any
);

  logic [NUM_SLOTS-1:0] sel;

  // isolate the lowest set bit with one wide add
  always_comb begin
    is_hit = |hit_vec;
    sel    = is_hit ? hit_vec : free_vec;
    any    = |sel;
    grant  = sel & (~sel + {{(NUM_SLOTS-1){1'b0}}, 1'b1});
  end

endmodule

[sv/keyed_slot_toggle_allocator.sv]
`timescale 1ns / 1ps
// Keyed slot toggle allocator: top level with sequencer, row of slot cells
// and picker. Depends on kst_pkg, kst_cell and kst_pick.
//
// Usage:
//   Input channel in_valid/in_stall carries a request of in_key and in_stamp.
//   A key that matches an occupied slot frees it and returns status release
//   with the 1-based slot and its stored stamp; otherwise the lowest free slot
//   takes key and stamp and returns status allocate; with no free slot the
//   result is status full, slot 0, time 0.
//   Output channel out_valid/out_stall carries out_status, out_slot and
//   out_time_out from an output register; exactly one result per request.
//   Timing: a request is taken in idle, then steps through compare, pick
//   and apply in turn; the result is registered at apply, and a new request
//   is taken only once the state is back in idle. The pick step (one wide add
//   across all slots) sets the per-step cycle time.
//   While out_stall holds a pending result, the apply step waits and
//   in_stall stays high. Reset empties every slot at once; key and stamp
//   storage are not cleared.
module keyed_slot_toggle_allocator
  import kst_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int KEY_BITS  = KEY_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KEY_W-1:0]    in_key,
  input  logic [STAMP_W-1:0]  in_stamp,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [SLOT_W-1:0]   out_slot,
  output logic [STAMP_W-1:0]  out_time_out
);

  localparam int IDX_W = $clog2(NUM_SLOTS + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_CMP   = 4'b0010,
    S_PICK  = 4'b0100,
    S_APPLY = 4'b1000
  } state_t;

  state_t                state_r, state_nxt;
  logic [KEY_BITS-1:0]   req_key_r;
  logic [STAMP_W-1:0]    req_stamp_r;
  logic [NUM_SLOTS-1:0]  grant_r;
  logic                  hit_sel_r;
  logic                  any_r;
  logic                  out_valid_r, out_valid_nxt;
  status_t               out_status_r;
  logic [SLOT_W-1:0]     out_slot_r;
  logic [STAMP_W-1:0]    out_time_r;

  logic                  accept;
  logic                  out_free;
  logic                  do_apply;
  cell_ctl_t             ctl;
  logic [NUM_SLOTS-1:0]  hit_vec, free_vec, pick_grant;
  logic                  pick_hit, pick_any;
  logic [STAMP_W-1:0]    cell_stamp [NUM_SLOTS];
  logic [STAMP_W-1:0]    rd_stamp;
  logic [IDX_W-1:0]      slot_num;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign do_apply = (state_r == S_APPLY) && out_free;

  always_comb begin
    ctl.cmp   = (state_r == S_CMP);
    ctl.apply = do_apply;
    ctl.alloc = !hit_sel_r;
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
    kst_cell #(
      .KEY_BITS (KEY_BITS)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .grant     (grant_r[g]),
      .req_key   (req_key_r),
      .req_stamp (req_stamp_r),
      .hit       (hit_vec[g]),
      .free      (free_vec[g]),
      .stamp     (cell_stamp[g])
    );
  end

  kst_pick #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_pick (
    .hit_vec  (hit_vec),
    .free_vec (free_vec),
    .grant    (pick_grant),
    .is_hit   (pick_hit),
    .any      (pick_any)
  );

  // read back the granted slot's stamp and number
  always_comb begin
    rd_stamp = '0;
    slot_num = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (grant_r[i]) begin
        rd_stamp = rd_stamp | cell_stamp[i];
        slot_num = slot_num | IDX_W'(i + 1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_CMP;
      S_CMP:   state_nxt = S_PICK;
      S_PICK:  state_nxt = S_APPLY;
      S_APPLY: if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (do_apply) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_key_r   <= KEY_BITS'(in_key);
      req_stamp_r <= in_stamp;
    end
    if (state_r == S_PICK) begin
      grant_r   <= pick_grant;
      hit_sel_r <= pick_hit;
      any_r     <= pick_any;
    end
    if (do_apply) begin
      if (!any_r) begin
        out_status_r <= ST_FULL;
        out_slot_r   <= '0;
        out_time_r   <= '0;
      end else if (hit_sel_r) begin
        out_status_r <= ST_RELEASE;
        out_slot_r   <= SLOT_W'(slot_num);
        out_time_r   <= rd_stamp;
      end else begin
        out_status_r <= ST_ALLOC;
        out_slot_r   <= SLOT_W'(slot_num);
        out_time_r   <= req_stamp_r;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_slot     = out_slot_r;
  assign out_time_out = out_time_r;

`include "assert_macros.svh"

  `KST_ASSERT(a_grant_onehot, (state_r != S_APPLY) || $onehot0(grant_r), "grant is not one-hot")
  `KST_ASSERT_NEXT(a_accept_to_cmp, accept, state_r == S_CMP, "request did not start compare")
  `KST_ASSERT(a_result_from_apply, !$rose(out_valid_r) || $past(do_apply), "stray result")

endmodule
